### rtl/wfe_pkg.sv
// Shared constants, types and the cosine table builder for the window and frame energy unit.
package wfe_pkg;

  // Sizing
  localparam int MAX_FRAME       = 1024;
  localparam int MIN_FRAME       = 2;
  localparam int COS_TABLE_DEPTH = 1024;
  localparam int SAMPLE_W        = 16;

  localparam int COS_AW  = $clog2(COS_TABLE_DEPTH);
  localparam int COS_W   = 17;                       // Q2.15 cosine, -1.0 .. +1.0
  localparam int PH_W    = 16;
  localparam int POS_W   = $clog2(MAX_FRAME);
  localparam int FL_W    = 11;
  localparam int WT_W    = 2;
  localparam int STEP_W  = 16;
  localparam int SUM_W   = 41;
  localparam int SQ_W    = 2 * SAMPLE_W - 1;         // square of a signed sample, unsigned
  localparam int WIN_W   = 16;                       // coefficient 0 .. 32768

  // Decoupling queue, depth must be a power of two
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TYPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd2;

  localparam logic [WT_W-1:0]   WINDOW_TYPE_RST  = 2'd0;
  localparam logic [FL_W-1:0]   FRAME_LENGTH_RST = 11'd256;
  localparam logic [STEP_W-1:0] PHASE_STEP_RST   = 16'd257;

  // Window shapes; the unused code falls through to Blackman
  localparam logic [WT_W-1:0] WIN_HANN     = 2'd0;
  localparam logic [WT_W-1:0] WIN_HAMMING  = 2'd1;
  localparam logic [WT_W-1:0] WIN_BLACKMAN = 2'd2;

  // Window terms, Q1.15 coefficients; A0 scaled to Q2.30
  localparam int W30_W = 34;
  localparam logic signed [W30_W-1:0] ONE_Q15    = 34'sd32768;
  localparam logic signed [W30_W-1:0] HANN_A0    = 34'sd16384 * ONE_Q15;
  localparam logic signed [W30_W-1:0] HANN_K1    = 34'sd16384;
  localparam logic signed [W30_W-1:0] HAMMING_A0 = 34'sd17695 * ONE_Q15;
  localparam logic signed [W30_W-1:0] HAMMING_K1 = 34'sd15073;
  localparam logic signed [W30_W-1:0] BLACK_A0   = 34'sd13763 * ONE_Q15;
  localparam logic signed [W30_W-1:0] BLACK_K1   = 34'sd16384;
  localparam logic signed [W30_W-1:0] BLACK_K2   = 34'sd2621;
  localparam logic signed [W30_W-1:0] ROUND_Q15  = 34'sd16384;

  typedef struct packed {
    logic [FL_W-1:0]   frame_length;
    logic [STEP_W-1:0] phase_step;
  } frame_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [COS_W-1:0]    c1;
    logic signed [COS_W-1:0]    c2;
    logic                       last;
  } q_entry_t;

  // Cosine table built at elaboration: fixed Q30 Taylor series, folded to one quadrant
  localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
  localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
  localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;

  typedef logic [COS_TABLE_DEPTH-1:0][COS_W-1:0] cos_tab_t;

  function automatic logic signed [63:0] cos_quadrant(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    x2   = (x * x) >> 30;
    term = 64'(ONE_Q30);
    acc  = ONE_Q30;
    term = ((term * x2) >> 30) / 64'd2;   acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd12;  acc = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd30;  acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd56;  acc = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd90;  acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd132; acc = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd182; acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd240; acc = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd306; acc = acc - $signed(term);
    if (acc < 0) acc = 0;
    if (acc > ONE_Q30) acc = ONE_Q30;
    return acc;
  endfunction

  function automatic logic signed [COS_W-1:0] cos_entry(input int k);
    logic signed [63:0] theta;
    logic signed [63:0] c;
    logic               neg;
    neg   = 1'b0;
    theta = (64'sd2 * PI_Q30 * 64'(k)) / COS_TABLE_DEPTH;
    if (theta > PI_Q30) theta = 64'sd2 * PI_Q30 - theta;
    if (theta > HALF_PI_Q30) begin
      theta = PI_Q30 - theta;
      neg   = 1'b1;
    end
    if (theta < 0) theta = 0;
    c = (cos_quadrant(theta) + 64'sd16384) >>> 15;
    return neg ? -COS_W'(c) : COS_W'(c);
  endfunction

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t t;
    int       k;
    for (k = 0; k < COS_TABLE_DEPTH; k++) begin
      t[k] = cos_entry(k);
    end
    return t;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

### rtl/wfe_ram.sv
// Generic RAM: one write port, two registered read ports.
module wfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

### rtl/wfe_front.sv
// Front end: table load, sample intake, frame position and phase, cosine lookup.
module wfe_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wfe_pkg::frame_cfg_t                 cfg,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic signed [wfe_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [wfe_pkg::Q_CW-1:0]            q_count,
  output logic                                q_push,
  output wfe_pkg::q_entry_t                   q_entry
);

  localparam int CNT_W  = wfe_pkg::COS_AW + 1;
  localparam int PROD_W = wfe_pkg::PH_W + wfe_pkg::COS_AW;
  localparam int CMP_W  =
    ((wfe_pkg::POS_W > wfe_pkg::FL_W) ? wfe_pkg::POS_W : wfe_pkg::FL_W) + 1;
  localparam int OCC_W  = wfe_pkg::Q_CW + 1;

  logic [CNT_W-1:0]                  fill_cnt_r;
  logic                              fill_done;
  logic [wfe_pkg::COS_AW-1:0]        fill_addr;
  logic [wfe_pkg::POS_W-1:0]         pos_r, pos_nxt;
  logic [wfe_pkg::PH_W-1:0]          phase_r, phase_nxt;
  logic [wfe_pkg::PH_W-1:0]          phase_dbl;
  logic [PROD_W-1:0]                 prod_a, prod_b;
  logic [wfe_pkg::COS_AW-1:0]        raddr_a, raddr_b;
  logic [wfe_pkg::COS_W-1:0]         rdata_a, rdata_b;
  logic [CMP_W-1:0]                  fl_ext, len_eff;
  logic                              last;
  logic                              accept;
  logic [OCC_W-1:0]                  occ;
  logic                              s1_v_r;
  logic signed [wfe_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic                              s1_last_r;

  // table load sweep after reset, one entry per cycle
  assign fill_done = (fill_cnt_r == CNT_W'(wfe_pkg::COS_TABLE_DEPTH));
  assign fill_addr = fill_cnt_r[wfe_pkg::COS_AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r <= '0;
    end else if (!fill_done) begin
      fill_cnt_r <= fill_cnt_r + CNT_W'(1);
    end
  end

  // phase -> table index, Blackman second term at doubled phase
  assign phase_dbl = {phase_r[wfe_pkg::PH_W-2:0], 1'b0};
  assign prod_a    = PROD_W'(phase_r)   * PROD_W'(wfe_pkg::COS_TABLE_DEPTH);
  assign prod_b    = PROD_W'(phase_dbl) * PROD_W'(wfe_pkg::COS_TABLE_DEPTH);
  assign raddr_a   = prod_a[PROD_W-1:wfe_pkg::PH_W];
  assign raddr_b   = prod_b[PROD_W-1:wfe_pkg::PH_W];

  wfe_ram #(
    .WIDTH (wfe_pkg::COS_W),
    .DEPTH (wfe_pkg::COS_TABLE_DEPTH)
  ) u_cos_ram (
    .clk     (clk),
    .we      (!fill_done),
    .waddr   (fill_addr),
    .wdata   (wfe_pkg::COS_TAB[fill_addr]),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // room for the beat in flight plus this one
  assign occ       = OCC_W'(q_count) + OCC_W'(s1_v_r);
  assign in_tready = fill_done && (occ < OCC_W'(wfe_pkg::Q_DEPTH));
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    fl_ext = CMP_W'(cfg.frame_length);
    if (fl_ext < CMP_W'(wfe_pkg::MIN_FRAME)) begin
      len_eff = CMP_W'(wfe_pkg::MIN_FRAME);
    end else if (fl_ext > CMP_W'(wfe_pkg::MAX_FRAME)) begin
      len_eff = CMP_W'(wfe_pkg::MAX_FRAME);
    end else begin
      len_eff = fl_ext;
    end
    last = (CMP_W'(pos_r) >= (len_eff - CMP_W'(1)));
    if (last) begin
      pos_nxt   = '0;
      phase_nxt = '0;
    end else begin
      pos_nxt   = pos_r + wfe_pkg::POS_W'(1);
      phase_nxt = phase_r + cfg.phase_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= '0;
      s1_v_r  <= 1'b0;
    end else begin
      s1_v_r <= accept;
      if (accept) begin
        pos_r   <= pos_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r <= in_sample;
      s1_last_r   <= last;
    end
  end

  // table data lands in the cycle after the beat
  assign q_push         = s1_v_r;
  assign q_entry.sample = s1_sample_r;
  assign q_entry.c1     = $signed(rdata_a);
  assign q_entry.c2     = $signed(rdata_b);
  assign q_entry.last   = s1_last_r;

endmodule

### rtl/wfe_queue.sv
// Short FIFO between front and back ends.
module wfe_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  wfe_pkg::q_entry_t          push_entry,
  input  logic                       pop,
  output wfe_pkg::q_entry_t          head,
  output logic                       empty,
  output logic [wfe_pkg::Q_CW-1:0]   count
);

  wfe_pkg::q_entry_t             mem_r [wfe_pkg::Q_DEPTH];
  logic [wfe_pkg::Q_AW-1:0]      wr_ptr_r;
  logic [wfe_pkg::Q_AW-1:0]      rd_ptr_r;
  logic [wfe_pkg::Q_CW-1:0]      count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + wfe_pkg::Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + wfe_pkg::Q_AW'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + wfe_pkg::Q_CW'(1);
        2'b01:   count_r <= count_r - wfe_pkg::Q_CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

### rtl/wfe_back.sv
// Back end: window coefficient, windowed sample, energy sums, output register.
module wfe_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [wfe_pkg::WT_W-1:0]            window_type,
  input  logic                                q_empty,
  input  wfe_pkg::q_entry_t                   q_head,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic signed [wfe_pkg::SAMPLE_W-1:0] windowed_sample,
  output logic [wfe_pkg::SUM_W-1:0]           raw_energy,
  output logic [wfe_pkg::SUM_W-1:0]           windowed_energy,
  output logic                                frame_end
);

  localparam int SW    = wfe_pkg::SAMPLE_W;
  localparam int W30W  = wfe_pkg::W30_W;
  localparam int WQ_W  = W30W - 15;
  localparam int P_W   = SW + wfe_pkg::WIN_W + 1;
  localparam int YS_W  = P_W + 1 - 15;
  localparam int SQP_W = 2 * SW;
  localparam logic signed [YS_W-1:0] Y_HI = YS_W'((1 << (SW - 1)) - 1);
  localparam logic signed [YS_W-1:0] Y_LO = -Y_HI - YS_W'(1);

  logic adv;

  // stage 1: coefficient and raw square
  logic signed [W30W-1:0]       c1x, c2x, w30, w30c, wsum;
  logic [WQ_W-1:0]              wq;
  logic [wfe_pkg::WIN_W-1:0]    w_nxt;
  logic signed [SQP_W-1:0]      sqr_prod;
  logic                         b1_v_r;
  logic signed [SW-1:0]         b1_sample_r;
  logic [wfe_pkg::WIN_W-1:0]    b1_w_r;
  logic [wfe_pkg::SQ_W-1:0]     b1_sqr_r;
  logic                         b1_last_r;

  // stage 2: windowed sample
  logic signed [P_W-1:0]        p;
  logic signed [P_W:0]          pr;
  logic signed [YS_W-1:0]       ys;
  logic signed [SW-1:0]         y_nxt;
  logic                         b2_v_r;
  logic signed [SW-1:0]         b2_y_r;
  logic [wfe_pkg::SQ_W-1:0]     b2_sqr_r;
  logic                         b2_last_r;

  // stage 3: windowed square
  logic signed [SQP_W-1:0]      sqy_prod;
  logic                         b3_v_r;
  logic signed [SW-1:0]         b3_y_r;
  logic [wfe_pkg::SQ_W-1:0]     b3_sqr_r;
  logic [wfe_pkg::SQ_W-1:0]     b3_sqy_r;
  logic                         b3_last_r;

  // stage 4: sums and output
  logic [wfe_pkg::SUM_W:0]      raw_add, win_add;
  logic [wfe_pkg::SUM_W-1:0]    raw_new, win_new;
  logic [wfe_pkg::SUM_W-1:0]    raw_sum_r, win_sum_r;
  logic                         out_v_r;
  logic signed [SW-1:0]         out_y_r;
  logic [wfe_pkg::SUM_W-1:0]    out_raw_r, out_win_r;
  logic                         out_last_r;

  // whole back pipe moves together, held by the output register
  assign adv   = !out_v_r || out_tready;
  assign q_pop = adv && !q_empty;

  always_comb begin
    c1x = W30W'(q_head.c1);
    c2x = W30W'(q_head.c2);
    case (window_type)
      wfe_pkg::WIN_HANN:    w30 = wfe_pkg::HANN_A0 - wfe_pkg::HANN_K1 * c1x;
      wfe_pkg::WIN_HAMMING: w30 = wfe_pkg::HAMMING_A0 - wfe_pkg::HAMMING_K1 * c1x;
      default:              w30 = wfe_pkg::BLACK_A0 - wfe_pkg::BLACK_K1 * c1x
                                  + wfe_pkg::BLACK_K2 * c2x;
    endcase
    w30c  = (w30 < 0) ? '0 : w30;
    wsum  = w30c + wfe_pkg::ROUND_Q15;
    wq    = wsum[W30W-1:15];
    w_nxt = (wq > WQ_W'(32768)) ? wfe_pkg::WIN_W'(32768) : wq[wfe_pkg::WIN_W-1:0];
  end

  assign sqr_prod = q_head.sample * q_head.sample;

  always_comb begin
    p  = b1_sample_r * $signed({1'b0, b1_w_r});
    pr = (P_W + 1)'(p) + (P_W + 1)'(16384);
    ys = pr[P_W:15];
    if (ys > Y_HI) begin
      y_nxt = Y_HI[SW-1:0];
    end else if (ys < Y_LO) begin
      y_nxt = Y_LO[SW-1:0];
    end else begin
      y_nxt = ys[SW-1:0];
    end
  end

  assign sqy_prod = b2_y_r * b2_y_r;

  // saturating accumulate at 2^41 - 1
  assign raw_add = {1'b0, raw_sum_r} + (wfe_pkg::SUM_W + 1)'(b3_sqr_r);
  assign win_add = {1'b0, win_sum_r} + (wfe_pkg::SUM_W + 1)'(b3_sqy_r);
  assign raw_new = raw_add[wfe_pkg::SUM_W] ? '1 : raw_add[wfe_pkg::SUM_W-1:0];
  assign win_new = win_add[wfe_pkg::SUM_W] ? '1 : win_add[wfe_pkg::SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r    <= 1'b0;
      b2_v_r    <= 1'b0;
      b3_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      raw_sum_r <= '0;
      win_sum_r <= '0;
    end else if (adv) begin
      b1_v_r  <= q_pop;
      b2_v_r  <= b1_v_r;
      b3_v_r  <= b2_v_r;
      out_v_r <= b3_v_r;
      if (b3_v_r) begin
        raw_sum_r <= b3_last_r ? '0 : raw_new;
        win_sum_r <= b3_last_r ? '0 : win_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_sample_r <= q_head.sample;
      b1_w_r      <= w_nxt;
      b1_sqr_r    <= sqr_prod[wfe_pkg::SQ_W-1:0];
      b1_last_r   <= q_head.last;

      b2_y_r      <= y_nxt;
      b2_sqr_r    <= b1_sqr_r;
      b2_last_r   <= b1_last_r;

      b3_y_r      <= b2_y_r;
      b3_sqr_r    <= b2_sqr_r;
      b3_sqy_r    <= sqy_prod[wfe_pkg::SQ_W-1:0];
      b3_last_r   <= b2_last_r;

      out_y_r     <= b3_y_r;
      out_raw_r   <= raw_new;
      out_win_r   <= win_new;
      out_last_r  <= b3_last_r;
    end
  end

  assign out_tvalid      = out_v_r;
  assign windowed_sample = out_y_r;
  assign raw_energy      = out_raw_r;
  assign windowed_energy = out_win_r;
  assign frame_end       = out_last_r;

endmodule

### rtl/window_and_frame_energy_unit.sv
// Top level of the window and frame energy unit.
// Hann / Hamming / Blackman windowing of a Q1.15 sample stream with per-frame energy sums.
// One sample beat in gives one result beat out; sustained rate is one beat per clock
// while the output is not stalled, set by the back-end pipeline, whose two running-sum
// adds are combinational. An accepted beat passes the front register, the queue, back
// stages b1, b2, b3 and the output register that drives out_tvalid. After reset a load
// pass fills the cosine table in RAM, with in_tready low until it ends; config writes are
// taken throughout (cfg_ready is always high). Writes are meant for an idle block only.
// Results carry the windowed sample, the raw and windowed energy summed so far in the
// frame (this sample included, saturating at 2^41-1) and tlast on the frame's last
// sample; position, phase and sums then restart from zero.
module window_and_frame_energy_unit (
  input  logic                               clk,
  input  logic                               rst_n,

  // config write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wfe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wfe_pkg::CFG_DATA_W-1:0]     cfg_data,

  // sample stream in
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,   // [15:0] sample

  // result stream out
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [103:0]                       out_tdata,  // [15:0] windowed_sample,
                                                         // [56:16] raw_energy,
                                                         // [97:57] windowed_energy,
                                                         // [103:98] zero
  output logic                               out_tlast   // frame_end
);

  logic [wfe_pkg::WT_W-1:0]   window_type_r;
  logic [wfe_pkg::FL_W-1:0]   frame_length_r;
  logic [wfe_pkg::STEP_W-1:0] phase_step_r;
  wfe_pkg::frame_cfg_t        frame_cfg;

  wfe_pkg::q_entry_t          push_entry;
  wfe_pkg::q_entry_t          q_head;
  logic                       q_push;
  logic                       q_pop;
  logic                       q_empty;
  logic [wfe_pkg::Q_CW-1:0]   q_count;

  logic signed [wfe_pkg::SAMPLE_W-1:0] windowed_sample;
  logic [wfe_pkg::SUM_W-1:0]           raw_energy;
  logic [wfe_pkg::SUM_W-1:0]           windowed_energy;

  // config registers, every beat taken; unknown index is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_type_r  <= wfe_pkg::WINDOW_TYPE_RST;
      frame_length_r <= wfe_pkg::FRAME_LENGTH_RST;
      phase_step_r   <= wfe_pkg::PHASE_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wfe_pkg::REG_WINDOW_TYPE:  window_type_r  <= cfg_data[wfe_pkg::WT_W-1:0];
        wfe_pkg::REG_FRAME_LENGTH: frame_length_r <= cfg_data[wfe_pkg::FL_W-1:0];
        wfe_pkg::REG_PHASE_STEP:   phase_step_r   <= cfg_data[wfe_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign frame_cfg.frame_length = frame_length_r;
  assign frame_cfg.phase_step   = phase_step_r;

  // front: intake, frame position, phase accumulator, cosine lookup
  wfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (frame_cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sample ($signed(in_tdata[wfe_pkg::SAMPLE_W-1:0])),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  // decoupling queue, lets the front keep taking beats while the output stalls
  wfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .count      (q_count)
  );

  // back: coefficient, multiply, energies, output register
  wfe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .window_type     (window_type_r),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .windowed_sample (windowed_sample),
    .raw_energy      (raw_energy),
    .windowed_energy (windowed_energy),
    .frame_end       (out_tlast)
  );

  assign out_tdata = {6'b0, windowed_energy, raw_energy, windowed_sample};

endmodule

### rtl/wfe_checker.sv
// Port-level checks for the window and frame energy unit, bound to the top level.
module wfe_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,
  input  logic         out_tlast
);

  localparam int CAP   = wfe_pkg::Q_DEPTH + 5;
  localparam int OC_W  = $clog2(CAP + 2);

  logic [OC_W-1:0] oc_r;
  logic            in_beat;
  logic            out_beat;

  assign in_beat  = in_tvalid && in_tready;
  assign out_beat = out_tvalid && out_tready;

  // beats accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oc_r <= '0;
    end else begin
      case ({in_beat, out_beat})
        2'b10:   oc_r <= oc_r + OC_W'(1);
        2'b01:   oc_r <= oc_r - OC_W'(1);
        default: oc_r <= oc_r;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat |-> oc_r != '0)
    else $error("result beat without a pending sample");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    oc_r <= OC_W'(CAP))
    else $error("more samples in flight than the pipe holds");

  a_table_load: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("sample taken before cosine table load");

  a_energy_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[97:57] <= out_tdata[56:16])
    else $error("windowed energy above raw energy");

endmodule

bind window_and_frame_energy_unit wfe_checker u_wfe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### verif/window_energy_checker.sv
// Predicts and checks every result beat of the window and frame energy unit.
module window_energy_checker
  import wfe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [15:0]           in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [103:0]          out_tdata,
  input  logic                  out_tlast,
  output int                    mismatches,
  output int                    pending
);

  localparam longint          ANGLE_PI      = 64'sd3373259426;
  localparam longint          ANGLE_HALF_PI = 64'sd1686629713;
  localparam longint          UNIT_Q30      = 64'sd1073741824;
  localparam longint unsigned ENERGY_MAX    = (64'd1 << SUM_W) - 64'd1;

  typedef struct {
    logic [SAMPLE_W-1:0] windowed;
    logic [SUM_W-1:0]    raw_energy;
    logic [SUM_W-1:0]    win_energy;
    logic                frame_end;
  } energy_beat_t;

  // register copies
  logic [WT_W-1:0]   win_shape;
  logic [FL_W-1:0]   frame_len;
  logic [STEP_W-1:0] step;

  // frame state
  int                position;
  logic [PH_W-1:0]   phase_acc;
  longint unsigned   raw_acc;
  longint unsigned   win_acc;

  logic signed [COS_W-1:0] cos_rom [COS_TABLE_DEPTH];
  energy_beat_t            window_results_due [$];

  // cos(x), x in [0, pi/2] as Q30, Taylor series through x^18 with truncating products
  function automatic longint taylor_cos(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x2   = (x * x) >> 30;
    term = UNIT_Q30;
    acc  = UNIT_Q30;
    for (int i = 1; i <= 9; i++) begin
      term = ((term * x2) >> 30) / longint'((2 * i - 1) * (2 * i));
      if (i % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > UNIT_Q30) acc = UNIT_Q30;
    return acc;
  endfunction

  function automatic logic signed [COS_W-1:0] rom_entry(input int k);
    longint theta;
    longint c;
    logic   neg;
    neg   = 1'b0;
    theta = (2 * ANGLE_PI * longint'(k)) / COS_TABLE_DEPTH;
    if (theta > ANGLE_PI) theta = 2 * ANGLE_PI - theta;
    if (theta > ANGLE_HALF_PI) begin
      theta = ANGLE_PI - theta;
      neg   = 1'b1;
    end
    if (theta < 0) theta = 0;
    c = (taylor_cos(longint'(theta)) + 16384) >>> 15;
    return neg ? COS_W'(-c) : COS_W'(c);
  endfunction

  initial begin
    for (int k = 0; k < COS_TABLE_DEPTH; k++) cos_rom[k] = rom_entry(k);
  end

  function automatic longint unsigned energy_add(input longint unsigned a,
                                                 input longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > ENERGY_MAX) ? ENERGY_MAX : s;
  endfunction

  // advances the frame state by one sample and returns the beat it must produce
  function automatic energy_beat_t predict_window_beat(input logic [SAMPLE_W-1:0] raw);
    longint          s;
    longint          c1;
    longint          c2;
    longint          w30;
    longint          w;
    longint          y;
    int              len;
    logic            last;
    logic [PH_W-1:0] ph2;
    energy_beat_t    r;
    s   = longint'($signed(raw));
    ph2 = {phase_acc[PH_W-2:0], 1'b0};
    c1  = cos_rom[phase_acc[PH_W-1 -: COS_AW]];
    c2  = cos_rom[ph2[PH_W-1 -: COS_AW]];
    case (win_shape)
      WIN_HANN:    w30 = 64'sd16384 * 32768 - 64'sd16384 * c1;
      WIN_HAMMING: w30 = 64'sd17695 * 32768 - 64'sd15073 * c1;
      default:     w30 = 64'sd13763 * 32768 - 64'sd16384 * c1 + 64'sd2621 * c2;
    endcase
    if (w30 < 0) w30 = 0;
    w = (w30 + 16384) >>> 15;
    if (w > 32768) w = 32768;
    y = (s * w + 16384) >>> 15;
    if (y > 32767)  y = 32767;
    if (y < -32768) y = -32768;

    raw_acc = energy_add(raw_acc, longint'(s * s));
    win_acc = energy_add(win_acc, longint'(y * y));

    len = int'(frame_len);
    if (len < MIN_FRAME) len = MIN_FRAME;
    if (len > MAX_FRAME) len = MAX_FRAME;
    last = (position >= len - 1);

    r.windowed   = y[SAMPLE_W-1:0];
    r.raw_energy = raw_acc[SUM_W-1:0];
    r.win_energy = win_acc[SUM_W-1:0];
    r.frame_end  = last;

    if (last) begin
      position  = 0;
      phase_acc = '0;
      raw_acc   = 0;
      win_acc   = 0;
    end else begin
      position  = position + 1;
      phase_acc = phase_acc + step;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    energy_beat_t due;
    if (!rst_n) begin
      win_shape = WINDOW_TYPE_RST;
      frame_len = FRAME_LENGTH_RST;
      step      = PHASE_STEP_RST;
      position  = 0;
      phase_acc = '0;
      raw_acc   = 0;
      win_acc   = 0;
      window_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_TYPE:  win_shape = cfg_data[WT_W-1:0];
          REG_FRAME_LENGTH: frame_len = cfg_data[FL_W-1:0];
          REG_PHASE_STEP:   step      = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (window_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result beat with nothing due: %h", out_tdata);
        end else begin
          due = window_results_due.pop_front();
          if (out_tdata[15:0] !== due.windowed || out_tdata[56:16] !== due.raw_energy ||
              out_tdata[97:57] !== due.win_energy || out_tlast !== due.frame_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch (exp/got): y %0d/%0d raw %0d/%0d win %0d/%0d end %b/%b",
                       $signed(due.windowed), $signed(out_tdata[15:0]),
                       due.raw_energy, out_tdata[56:16], due.win_energy, out_tdata[97:57],
                       due.frame_end, out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) window_results_due.push_back(predict_window_beat(in_tdata));
    end
    pending = window_results_due.size();
  end

endmodule

### verif/window_and_frame_energy_unit_tb.sv
// Stimulus and verdict for the window and frame energy unit; checking sits in the checker.
module window_and_frame_energy_unit_tb;
  import wfe_pkg::*;

  // code 3 has no shape of its own; the block decodes it as Blackman
  localparam logic [WT_W-1:0] WIN_SPARE = 2'd3;

  localparam int LONG_HOLD     = 150;  // receiver hold-off, long enough to back up the block
  localparam int RANDOM_PHASES = 22;   // ~25 beats each
  localparam int HOLD_PHASE    = 3;
  localparam int DRAIN_CYCLES  = 20;   // idle wait at the end for stray result beats

  typedef enum int {PICK_CORNER, PICK_MIXED} pick_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;    // [15:0] sample
  logic                  out_tvalid;
  logic                  out_tready;
  logic [103:0]          out_tdata;   // [15:0] windowed_sample, [56:16] raw_energy,
                                      // [97:57] windowed_energy, [103:98] zero
  logic                  out_tlast;   // frame_end

  int mismatches;
  int pending;

  // shared between sender and receiver
  bit no_gaps;       // both sides run flat out while set
  int hold_req;      // bumped by the sender to ask for one long receiver hold-off
  int hold_served;

  logic [15:0] corner_vals [7] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                   16'h0001, 16'h5555, 16'hAAAA};
  int corner_idx;

  window_and_frame_energy_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  window_energy_checker energy_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop; the slowest legal run (table load, up to 795 beats with
  // worst gaps on both sides, one long hold-off) is well under a tenth of this
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: per beat, a random hold-off, plus the long one when asked.
  // tready only moves on falling edges, one assignment per edge.
  initial begin
    int hold;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 6);
      if (hold_req != hold_served) begin
        hold        = hold + LONG_HOLD;
        hold_served = hold_req;
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // One config write; valid stays up so back-to-back writes need no drop in between.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Block must be idle here: every due result has arrived.
  task automatic set_window(input logic [CFG_DATA_W-1:0] shape,
                            input logic [CFG_DATA_W-1:0] len,
                            input logic [CFG_DATA_W-1:0] ph_step);
    write_reg(REG_WINDOW_TYPE, shape);
    write_reg(REG_FRAME_LENGTH, len);
    write_reg(REG_PHASE_STEP, ph_step);
    cfg_valid <= 1'b0;
  endtask

  // Sender: random gap, then hold the beat until accepted. Called on a falling edge.
  task automatic offer_sample(input logic [15:0] value);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [15:0] draw_sample(input pick_t style);
    logic [15:0] v;
    int          r;
    r = $urandom_range(0, 9);
    if (style == PICK_CORNER || r >= 8) begin
      v          = corner_vals[corner_idx % 7];
      corner_idx = corner_idx + 1;
    end else if (r >= 6) begin
      v = 16'($urandom_range(0, 511) - 256);   // quiet signal around zero
    end else begin
      v = 16'($urandom);
    end
    return v;
  endfunction

  // n beats, then wait until every result has come back
  task automatic run_batch(input int n, input pick_t style);
    for (int i = 0; i < n; i++) offer_sample(draw_sample(style));
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int                    eff_len;
    int                    r;
    int                    n;
    logic [CFG_DATA_W-1:0] shape_val;
    logic [CFG_DATA_W-1:0] len_val;
    logic [CFG_DATA_W-1:0] step_val;

    cfg_valid   = 1'b0;
    cfg_index   = REG_WINDOW_TYPE;
    cfg_data    = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    rst_n       = 1'b0;
    no_gaps     = 1'b0;
    hold_req    = 0;
    hold_served = 0;
    corner_idx  = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    // reset settings: Hann, N=256, step 257; first beats wait out the table load
    run_batch(5, PICK_CORNER);
    // Hamming, shortest frame, half-turn step: cos = -1 drives the coefficient to 1.0;
    // frame already past its end, so the first beat closes it
    set_window(CFG_DATA_W'(WIN_HAMMING), 16'd2, 16'h8000);
    run_batch(4, PICK_CORNER);
    // Blackman, length 0 acts as 2, largest step (phase wrap, doubled phase)
    set_window(CFG_DATA_W'(WIN_BLACKMAN), 16'd0, 16'hFFFF);
    run_batch(3, PICK_CORNER);
    // spare window code, length 1 acts as 2
    set_window(CFG_DATA_W'(WIN_SPARE), 16'd1, 16'd21845);
    run_batch(3, PICK_CORNER);
    // all-ones length acts as MAX_FRAME; zero step holds the phase
    set_window(CFG_DATA_W'(WIN_HANN), 16'd2047, 16'd0);
    run_batch(3, PICK_CORNER);
    set_window(CFG_DATA_W'(WIN_HAMMING), 16'd1024, 16'd64);
    run_batch(4, PICK_CORNER);
    // length cut below the current position: frame ends on the next beat
    set_window(CFG_DATA_W'(WIN_BLACKMAN), 16'd3, 16'hFFFF);
    run_batch(3, PICK_CORNER);

    // --- random part ---
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // shape: mostly legal codes, sometimes junk in the upper data bits
      shape_val = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));

      // length: mostly short frames so many of them close
      r = $urandom_range(0, 9);
      if (r < 6)       len_val = 16'($urandom_range(2, 40));
      else if (r == 6) len_val = 16'($urandom_range(0, 1));
      else if (r == 7) len_val = 16'($urandom_range(41, 1024));
      else if (r == 8) len_val = ($urandom_range(0, 1) == 1) ? 16'd2047 : 16'd1024;
      else             len_val = 16'($urandom);

      eff_len = int'(len_val[FL_W-1:0]);
      if (eff_len < MIN_FRAME) eff_len = MIN_FRAME;
      if (eff_len > MAX_FRAME) eff_len = MAX_FRAME;

      // step: usually matched to the length, otherwise anything
      r = $urandom_range(0, 5);
      if (r < 3)       step_val = 16'((65536 + (eff_len - 1) / 2) / (eff_len - 1));
      else if (r == 3) step_val = 16'($urandom);
      else if (r == 4) step_val = 16'd0;
      else             step_val = 16'hFFFF;

      set_window(shape_val, len_val, step_val);
      no_gaps = ($urandom_range(0, 4) == 0);
      n       = $urandom_range(15, 35);
      if (p == HOLD_PHASE) begin
        // sender keeps pushing while the receiver sits idle: block fills and stalls input
        no_gaps  = 1'b1;
        n        = 35;
        hold_req = hold_req + 1;
      end
      run_batch(n, PICK_MIXED);
    end

    // nothing due any more; give stray beats a chance to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/wfe_pkg.sv
rtl/wfe_ram.sv
rtl/wfe_front.sv
rtl/wfe_queue.sv
rtl/wfe_back.sv
rtl/window_and_frame_energy_unit.sv
rtl/wfe_checker.sv
verif/window_energy_checker.sv
verif/window_and_frame_energy_unit_tb.sv
